// ===== rtl/core/gcda_pkg.sv =====
// ----------------------------------------------------------------------------
// gcda_pkg: shared types and constants for the great-circle distance block
// Holds the CORDIC datapath types, the fixed-point formats and the arctangent
// table and gain constants, which are all built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package gcda_pkg;

   // Number of CORDIC cells in each rotation or vectoring row.
   localparam int STEPS = 48;
   // Vector components are Q56, internal angles are degrees in Q40.
   localparam int VQ = 56;
   localparam int AQ = 40;

   typedef logic signed [63:0] s64_type;
   typedef s64_type turn_tab_type [STEPS];

   // One CORDIC vector with its angle accumulator.
   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } cordic_type;

   localparam s64_type ONE_V = 64'sd1 <<< VQ;
   localparam s64_type HALF_Q = 64'sd180 <<< AQ;
   localparam s64_type R_SEED = (ONE_V / 10) * 3;
   localparam s64_type G_SEED = (ONE_V / 5) * 3;

   // Restoring division, used only while the constants are elaborated.
   function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Product scaled down by 2^sh, rounded half away from zero.
   function automatic s64_type mulsh(s64_type a, s64_type b, int sh);
      logic neg;
      logic [63:0] ua;
      logic [63:0] ub;
      logic [127:0] prod;
      logic [127:0] r;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? 64'(-a) : 64'(a);
      ub = (b < 0) ? 64'(-b) : 64'(b);
      prod = 128'(ua) * 128'(ub);
      prod = prod + (128'd1 << (sh - 1));
      r = prod >> sh;
      return neg ? -s64_type'(r[63:0]) : s64_type'(r[63:0]);
   endfunction

   function automatic s64_type mulq(s64_type a, s64_type b);
      return mulsh(a, b, VQ);
   endfunction

   // Newton iteration for 1/x from a seed.
   function automatic s64_type recip(s64_type x, s64_type y0);
      s64_type y;
      y = y0;
      for (int k = 0; k < 8; k++) begin
         y = mulq(y, 2 * ONE_V - mulq(x, y));
      end
      return y;
   endfunction

   // atan(2^-i) in Q60 radians by its power series.
   function automatic s64_type atan_pow2(int i);
      logic [63:0] p;
      logic [63:0] t;
      logic [63:0] k;
      s64_type sum;
      p = 64'd1 << (60 - i);
      t = '0;
      k = '0;
      sum = '0;
      for (int n = 0; n < 64; n++) begin
         if (p == 0) break;
         t = udiv(p, 2 * k + 1);
         sum = k[0] ? sum - s64_type'(t) : sum + s64_type'(t);
         if (2 * i >= 64) break;
         p = p >> (2 * i);
         k = k + 1;
      end
      return sum;
   endfunction

   // atan(1/3) in Q60 radians.
   function automatic s64_type atan_third();
      logic [63:0] p;
      logic [63:0] t;
      logic [63:0] k;
      s64_type sum;
      p = udiv(64'd1 << 60, 64'd3);
      t = '0;
      k = '0;
      sum = '0;
      for (int n = 0; n < 64; n++) begin
         if (p == 0) break;
         t = udiv(p, 2 * k + 1);
         sum = k[0] ? sum - s64_type'(t) : sum + s64_type'(t);
         p = udiv(p, 64'd9);
         k = k + 1;
      end
      return sum;
   endfunction

   // Step angles in Q40 degrees.
   function automatic turn_tab_type build_turn();
      turn_tab_type t;
      s64_type a0;
      s64_type pi56;
      s64_type r56;
      s64_type ar;
      a0 = atan_third() + atan_pow2(1);
      pi56 = (4 * a0 + 8) >>> 4;
      r56 = 180 * recip(pi56, R_SEED);
      for (int i = 0; i < STEPS; i++) begin
         ar = (i == 0) ? a0 : atan_pow2(i);
         t[i] = mulsh(ar, r56, 60 + VQ - AQ);
      end
      return t;
   endfunction

   // Gain of a full rotation row, found by running one at zero angle.
   function automatic s64_type calc_gain(turn_tab_type t);
      s64_type x;
      s64_type y;
      s64_type z;
      s64_type xs;
      s64_type ys;
      x = ONE_V;
      y = '0;
      z = '0;
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - t[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + t[i];
         end
      end
      return x;
   endfunction

   localparam turn_tab_type TURN_DEG = build_turn();
   localparam s64_type GAIN_K = calc_gain(TURN_DEG);
   localparam s64_type INV_GAIN = recip(GAIN_K, G_SEED);

endpackage

`default_nettype wire

// ===== rtl/core/gcda_if.sv =====
// ----------------------------------------------------------------------------
// gcda_if: request and response channels of the distance block
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcda_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] lat_a;
   logic signed [24:0] lon_a;
   logic signed [23:0] lat_b;
   logic signed [24:0] lon_b;

   modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
   modport sink (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface gcda_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] distance;
   logic [24:0] azimuth;

   modport source (output valid, distance, azimuth, input ready);
   modport sink (input valid, distance, azimuth, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gcda_delay.sv =====
// ----------------------------------------------------------------------------
// gcda_delay: enabled shift line
// Carries side data alongside the CORDIC rows and multipliers for DEPTH stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gcda_delay #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  wire logic         clock,
   input  wire logic         en,
   input  wire logic [W-1:0] d,
   output logic      [W-1:0] q
);

   logic [W-1:0] tap_ff [DEPTH];
   logic [W-1:0] tap_in [DEPTH];

   // Each tap takes the one before it.
   always_comb begin
      tap_in[0] = d;
      for (int i = 1; i < DEPTH; i++) begin
         tap_in[i] = tap_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff <= tap_in;
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/core/gcda_mul.sv =====
// ----------------------------------------------------------------------------
// gcda_mul: two-stage Q56 multiplier
// Splits a 64x64 product into four 32x32 partial products, then sums them
// and rounds half away from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module gcda_mul
   import gcda_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    en,
   input  wire s64_type a,
   input  wire s64_type b,
   output s64_type      p
);

   logic [63:0] ua;
   logic [63:0] ub;
   logic        neg_in;
   logic        neg_ff;
   logic [63:0] pp_in [4];
   logic [63:0] pp_ff [4];
   logic [127:0] sum;
   logic [63:0] mag;
   s64_type     p_in;
   s64_type     p_ff;

   // First stage: magnitudes and the partial products.
   always_comb begin
      neg_in = a[63] != b[63];
      ua = a[63] ? 64'(-a) : 64'(a);
      ub = b[63] ? 64'(-b) : 64'(b);
      pp_in[0] = 64'(ua[31:0]) * 64'(ub[31:0]);
      pp_in[1] = 64'(ua[31:0]) * 64'(ub[63:32]);
      pp_in[2] = 64'(ua[63:32]) * 64'(ub[31:0]);
      pp_in[3] = 64'(ua[63:32]) * 64'(ub[63:32]);
   end

   // Second stage: sum, round and restore the sign.
   always_comb begin
      sum = 128'(pp_ff[0]) + (128'(pp_ff[1]) << 32) + (128'(pp_ff[2]) << 32)
            + (128'(pp_ff[3]) << 64) + (128'd1 << (VQ - 1));
      mag = sum[VQ+63:VQ];
      p_in = neg_ff ? -s64_type'(mag) : s64_type'(mag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff <= neg_in;
         pp_ff  <= pp_in;
         p_ff   <= p_in;
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gcda_rot_cell.sv =====
// ----------------------------------------------------------------------------
// gcda_rot_cell: one CORDIC rotation cell
// Turns the vector by the fixed step angle toward the remaining angle.
// ----------------------------------------------------------------------------
`default_nettype none

module gcda_rot_cell
   import gcda_pkg::*;
#(
   parameter int STEP = 0
) (
   input  wire logic       clock,
   input  wire logic       en,
   input  wire cordic_type up,
   output cordic_type      dn
);

   s64_type    xs;
   s64_type    ys;
   cordic_type cell_in;
   cordic_type cell_ff;

   // Direction follows the sign of the remaining angle.
   always_comb begin
      xs = up.x >>> STEP;
      ys = up.y >>> STEP;
      if (!up.z[63]) begin
         cell_in.x = up.x - ys;
         cell_in.y = up.y + xs;
         cell_in.z = up.z - TURN_DEG[STEP];
      end else begin
         cell_in.x = up.x + ys;
         cell_in.y = up.y - xs;
         cell_in.z = up.z + TURN_DEG[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign dn = cell_ff;

endmodule

`default_nettype wire

// ===== rtl/core/gcda_vec_cell.sv =====
// ----------------------------------------------------------------------------
// gcda_vec_cell: one CORDIC vectoring cell
// Turns the vector toward the x axis and accumulates the angle taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gcda_vec_cell
   import gcda_pkg::*;
#(
   parameter int STEP = 0
) (
   input  wire logic       clock,
   input  wire logic       en,
   input  wire cordic_type up,
   output cordic_type      dn
);

   s64_type    xs;
   s64_type    ys;
   cordic_type cell_in;
   cordic_type cell_ff;

   // Direction follows the sign of y.
   always_comb begin
      xs = up.x >>> STEP;
      ys = up.y >>> STEP;
      if (up.y[63]) begin
         cell_in.x = up.x - ys;
         cell_in.y = up.y + xs;
         cell_in.z = up.z - TURN_DEG[STEP];
      end else begin
         cell_in.x = up.x + ys;
         cell_in.y = up.y - xs;
         cell_in.z = up.z + TURN_DEG[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign dn = cell_ff;

endmodule

`default_nettype wire

// ===== rtl/core/great_circle_distance_azimuth.sv =====
// ----------------------------------------------------------------------------
// great_circle_distance_azimuth: distance and azimuth between two points
// Rotates the second point into the frame of the first with CORDIC sine and
// cosine rows, then finds azimuth and distance with two CORDIC vectoring rows.
//
//   Channel   Dir   Beat contents
//   req_ch    in    lat_a, lon_a, lat_b, lon_b (degrees * 2^ANGLE_FRAC_BITS)
//   rsp_ch    out   distance, azimuth (degrees * 2^ANGLE_FRAC_BITS)
//
// One beat is taken every cycle unless a result beat waits; each result
// passes range reduction, a 48-cell rotation row, multipliers, two vectoring rows.
// Reset clears only the valid line; the datapath carries no reset.
// When a result beat waits on rsp_ch, the whole pipeline holds and req_ch
// ready drops for that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_distance_azimuth
   import gcda_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   gcda_req_if.sink    req_ch,
   gcda_rsp_if.source  rsp_ch
);

   localparam int F       = ANGLE_FRAC_BITS;
   localparam int SHIFT_P = AQ - F;
   localparam int LAT     = 158;
   localparam logic [63:0] FULL = 64'd360 << F;
   localparam s64_type FULL_S = s64_type'(FULL);
   localparam s64_type HALF_S = s64_type'(64'd180 << F);
   // Range reduction: quotient by reciprocal, one correction step.
   localparam int FCLOG = $clog2(FULL);
   localparam int SH    = 30 + FCLOG;
   localparam logic [31:0] RECIP = 32'((64'd1 << SH) / FULL);
   localparam int QW = (FCLOG < 27) ? 28 - FCLOG : 1;
   localparam int MU = F + 11;
   localparam logic signed [MU-1:0] FULL_M = MU'(64'd360 << F);
   localparam logic signed [MU-1:0] HALF_M = MU'(64'd180 << F);
   localparam logic signed [MU-1:0] QTR_M  = MU'(64'd90 << F);

   typedef struct packed {
      cordic_type c;
      logic       zero;
   } vinit_type;

   // Start of a vectoring row: fold into the right half plane.
   function automatic vinit_type vec_init(s64_type x, s64_type y);
      vinit_type r;
      r.zero = (x == 0) && (y == 0);
      r.c.x = x;
      r.c.y = y;
      r.c.z = '0;
      if (x < 0) begin
         r.c.z = (y >= 0) ? HALF_Q : -HALF_Q;
         r.c.x = -x;
         r.c.y = -y;
      end
      return r;
   endfunction

   // Q40 degrees to port format, rounded half up.
   function automatic s64_type to_port(s64_type z);
      return (z + (64'sd1 <<< (SHIFT_P - 1))) >>> SHIFT_P;
   endfunction

   logic en;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   // Pipeline advances unless a finished beat waits.
   assign en = !vld_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = en;
   assign rsp_ch.valid = vld_ff[LAT-1];

   always_comb begin
      vld_in = {vld_ff[LAT-2:0], req_ch.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: the three angles (lat a, lat b, longitude difference).
   logic signed [25:0] ang_ff [3];
   logic signed [25:0] ang_in [3];
   logic eq_ff;
   logic eq_in;

   always_comb begin
      ang_in[0] = 26'(req_ch.lat_a);
      ang_in[1] = 26'(req_ch.lat_b);
      ang_in[2] = 26'(req_ch.lon_b) - 26'(req_ch.lon_a);
      eq_in = req_ch.lat_a == req_ch.lat_b;
   end

   // Stage 2: magnitude and quotient estimate by a full turn.
   logic [25:0]   av_ff [3];
   logic [25:0]   av_in [3];
   logic [QW-1:0] q_ff [3];
   logic [QW-1:0] q_in [3];
   logic [2:0]    neg_ff;
   logic [2:0]    neg_in;
   logic          eq2_ff;
   logic [57:0]   qprod [3];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         neg_in[l] = ang_ff[l][25];
         av_in[l] = ang_ff[l][25] ? 26'(-ang_ff[l]) : 26'(ang_ff[l]);
         qprod[l] = 58'(av_in[l]) * 58'(RECIP);
         q_in[l] = QW'(qprod[l] >> SH);
      end
   end

   // Stage 3: remainder, sign restored; coincidence known here.
   logic [MU-1:0]        mm [3];
   logic signed [MU-1:0] m_ff [3];
   logic signed [MU-1:0] m_in [3];
   logic                 coinc_ff;
   logic                 coinc_in;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mm[l] = MU'(av_ff[l]) - MU'(q_ff[l]) * MU'(FULL);
         if (mm[l] >= MU'(FULL)) begin
            mm[l] = mm[l] - MU'(FULL);
         end
         m_in[l] = neg_ff[l] ? -$signed(mm[l]) : $signed(mm[l]);
      end
      coinc_in = eq2_ff && (mm[2] == '0);
   end

   // Stage 4: fold into -90 to +90 degrees and scale to Q40.
   logic signed [MU-1:0] fm [3];
   s64_type              z_ff [3];
   s64_type              z_in [3];
   logic [2:0]           flip_ff;
   logic [2:0]           flip_in;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         fm[l] = m_ff[l];
         flip_in[l] = 1'b0;
         if (fm[l] > HALF_M) begin
            fm[l] = fm[l] - FULL_M;
         end else if (fm[l] < -HALF_M) begin
            fm[l] = fm[l] + FULL_M;
         end
         if (fm[l] > QTR_M) begin
            fm[l] = fm[l] - HALF_M;
            flip_in[l] = 1'b1;
         end else if (fm[l] < -QTR_M) begin
            fm[l] = fm[l] + HALF_M;
            flip_in[l] = 1'b1;
         end
         z_in[l] = s64_type'(fm[l]) <<< SHIFT_P;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff   <= ang_in;
         eq_ff    <= eq_in;
         av_ff    <= av_in;
         q_ff     <= q_in;
         neg_ff   <= neg_in;
         eq2_ff   <= eq_ff;
         m_ff     <= m_in;
         coinc_ff <= coinc_in;
         z_ff     <= z_in;
         flip_ff  <= flip_in;
      end
   end

   // Sine and cosine rows, one per angle.
   cordic_type rot_c [3][STEPS+1];
   logic [2:0] flip_d;

   for (genvar l = 0; l < 3; l++) begin : g_lane
      assign rot_c[l][0] = '{x: INV_GAIN, y: '0, z: z_ff[l]};
      for (genvar i = 0; i < STEPS; i++) begin : g_cell
         gcda_rot_cell #(.STEP(i)) u_cell (
            .clock (clock),
            .en    (en),
            .up    (rot_c[l][i]),
            .dn    (rot_c[l][i+1])
         );
      end
   end

   gcda_delay #(.W(3), .DEPTH(STEPS)) u_flip_dly (
      .clock (clock), .en (en), .d (flip_ff), .q (flip_d)
   );

   // Trig stage: undo the half-turn fold.
   s64_type cos_ff [3];
   s64_type cos_in [3];
   s64_type sin_ff [3];
   s64_type sin_in [3];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         cos_in[l] = flip_d[l] ? -rot_c[l][STEPS].x : rot_c[l][STEPS].x;
         sin_in[l] = flip_d[l] ? -rot_c[l][STEPS].y : rot_c[l][STEPS].y;
      end
   end

   // Second point in the frame of the first.
   s64_type pcc;
   s64_type pry;
   logic [191:0] trig_d;

   gcda_mul u_mul_cc (.clock(clock), .en(en), .a(cos_ff[1]), .b(cos_ff[2]), .p(pcc));
   gcda_mul u_mul_ry (.clock(clock), .en(en), .a(cos_ff[1]), .b(sin_ff[2]), .p(pry));

   gcda_delay #(.W(192), .DEPTH(2)) u_trig_dly (
      .clock (clock), .en (en),
      .d     ({cos_ff[0], sin_ff[0], sin_ff[1]}),
      .q     (trig_d)
   );

   s64_type dx_ff, dx_in, dz_ff, dz_in, ry_ff, ry_in, ca_ff, ca_in, sa_ff, sa_in;

   always_comb begin
      ca_in = trig_d[191:128];
      sa_in = trig_d[127:64];
      dx_in = pcc - ca_in;
      dz_in = s64_type'(trig_d[63:0]) - sa_in;
      ry_in = pry;
   end

   s64_type m1, m2, m3, m4;
   logic [63:0] ry_d;

   gcda_mul u_mul_1 (.clock(clock), .en(en), .a(dx_ff), .b(ca_ff), .p(m1));
   gcda_mul u_mul_2 (.clock(clock), .en(en), .a(dz_ff), .b(sa_ff), .p(m2));
   gcda_mul u_mul_3 (.clock(clock), .en(en), .a(dz_ff), .b(ca_ff), .p(m3));
   gcda_mul u_mul_4 (.clock(clock), .en(en), .a(dx_ff), .b(sa_ff), .p(m4));

   gcda_delay #(.W(64), .DEPTH(2)) u_ry_dly (
      .clock (clock), .en (en), .d (ry_ff), .q (ry_d)
   );

   s64_type rx_ff, rx_in, rz_ff, rz_in, ry3_ff, ry3_in;

   always_comb begin
      rx_in = m1 + m2;
      rz_in = m3 - m4;
      ry3_in = s64_type'(ry_d);
   end

   // Radial term for the distance row, scaled by the CORDIC gain.
   s64_type xd;
   logic [63:0] xd_d;

   gcda_mul u_mul_rad (.clock(clock), .en(en), .a(ONE_V + rx_ff), .b(GAIN_K), .p(xd));

   gcda_delay #(.W(64), .DEPTH(STEPS - 1)) u_xd_dly (
      .clock (clock), .en (en), .d (xd), .q (xd_d)
   );

   // Azimuth row.
   vinit_type  v1_in;
   cordic_type v1_c [STEPS+1];
   logic       zero1_ff;
   logic       zero1_d;

   always_comb begin
      v1_in = vec_init(rz_ff, ry3_ff);
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_v1
      gcda_vec_cell #(.STEP(i)) u_cell (
         .clock (clock), .en (en), .up (v1_c[i]), .dn (v1_c[i+1])
      );
   end

   gcda_delay #(.W(1), .DEPTH(STEPS)) u_zero1_dly (
      .clock (clock), .en (en), .d (zero1_ff), .q (zero1_d)
   );

   // Distance row, fed by the horizontal magnitude.
   vinit_type  v2_in;
   cordic_type v2_c [STEPS+1];
   logic       zero2_ff;
   logic       zero2_d;
   s64_type    az_ff;
   s64_type    az_in;
   logic [63:0] az_d;

   always_comb begin
      az_in = to_port(zero1_d ? '0 : v1_c[STEPS].z);
      v2_in = vec_init(s64_type'(xd_d), zero1_d ? '0 : v1_c[STEPS].x);
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_v2
      gcda_vec_cell #(.STEP(i)) u_cell (
         .clock (clock), .en (en), .up (v2_c[i]), .dn (v2_c[i+1])
      );
   end

   gcda_delay #(.W(1), .DEPTH(STEPS)) u_zero2_dly (
      .clock (clock), .en (en), .d (zero2_ff), .q (zero2_d)
   );

   gcda_delay #(.W(64), .DEPTH(STEPS)) u_az_dly (
      .clock (clock), .en (en), .d (az_ff), .q (az_d)
   );

   logic coinc_d;

   gcda_delay #(.W(1), .DEPTH(LAT - 4)) u_coinc_dly (
      .clock (clock), .en (en), .d (coinc_ff), .q (coinc_d)
   );

   // Output stage: clamp distance, wrap azimuth, zero coincident points.
   s64_type dist_w;
   s64_type azw;
   logic [23:0] dist_ff, dist_in;
   logic [24:0] azo_ff, azo_in;

   always_comb begin
      dist_w = to_port(zero2_d ? '0 : v2_c[STEPS].z);
      if (dist_w < 0) begin
         dist_w = '0;
      end
      if (dist_w > HALF_S) begin
         dist_w = HALF_S;
      end
      azw = s64_type'(az_d);
      if (azw < 0) begin
         azw = azw + FULL_S;
      end
      if (azw >= FULL_S) begin
         azw = azw - FULL_S;
      end
      dist_in = coinc_d ? '0 : dist_w[23:0];
      azo_in = coinc_d ? '0 : azw[24:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff   <= cos_in;
         sin_ff   <= sin_in;
         dx_ff    <= dx_in;
         dz_ff    <= dz_in;
         ry_ff    <= ry_in;
         ca_ff    <= ca_in;
         sa_ff    <= sa_in;
         rx_ff    <= rx_in;
         rz_ff    <= rz_in;
         ry3_ff   <= ry3_in;
         v1_c[0]  <= v1_in.c;
         zero1_ff <= v1_in.zero;
         v2_c[0]  <= v2_in.c;
         zero2_ff <= v2_in.zero;
         az_ff    <= az_in;
         dist_ff  <= dist_in;
         azo_ff   <= azo_in;
      end
   end

   assign rsp_ch.distance = dist_ff;
   assign rsp_ch.azimuth  = azo_ff;

   // A waiting result beat freezes every stage.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> $stable(vld_ff))
      else $error("pipeline moved while the result beat waited");

   // Results stay inside their ranges.
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (64'(rsp_ch.distance) <= 64'(HALF_S))
                    && (64'(rsp_ch.azimuth) < FULL))
      else $error("result beat out of range");

   // Reset leaves the pipeline empty.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (vld_ff == '0))
      else $error("valid line not cleared by reset");

endmodule

`default_nettype wire
